[hw/rtl/nbrt_pkg.sv]
// ----------------------------------------------------------------------------
// nbrt_pkg: shared types and constants of the nearest box region table
// Command, status and sequencer codes, item structs and field widths.
// ----------------------------------------------------------------------------
package nbrt_pkg;

   localparam int MAX_BOXES_DEFAULT = 64;

   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int COORD_W    = 19;
   localparam int POS_W      = 20;
   localparam int SUM_W      = 22;
   localparam int MARGIN_W   = 12;
   localparam int ENTRY_W    = 6;
   localparam int BEST_W     = 24;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 32;

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd512;
   // Start value of the best excess: 999999 units at 1/16 resolution.
   localparam logic [BEST_W-1:0]   EXCESS_INIT  = 24'd15999984;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic {
      UOP_SORT = 1'b0,
      UOP_DIST = 1'b1
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_AXIS,
      ST_ADD_WRITE,
      ST_LK_AXIS,
      ST_LK_CMP,
      ST_DEL_READ,
      ST_DEL_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [COORD_W-1:0]  a_x;
      logic signed [COORD_W-1:0]  a_y;
      logic signed [COORD_W-1:0]  a_z;
      logic signed [COORD_W-1:0]  b_x;
      logic signed [COORD_W-1:0]  b_y;
      logic signed [COORD_W-1:0]  b_z;
      logic [ENTRY_W-1:0]         entry_index;
   } req_item_type;

   typedef struct packed {
      status_type          status;
      logic                inside_res;
      logic [ENTRY_W-1:0]  entry;
      logic [SUM_W-1:0]    excess;
   } rsp_item_type;

   typedef struct packed {
      logic [SUM_W-1:0]          ext;
      logic signed [POS_W-1:0]   hi_z;
      logic signed [POS_W-1:0]   hi_y;
      logic signed [POS_W-1:0]   hi_x;
      logic signed [POS_W-1:0]   lo_z;
      logic signed [POS_W-1:0]   lo_y;
      logic signed [POS_W-1:0]   lo_x;
   } box_entry_type;

   typedef struct packed {
      logic ready;
      logic done;
   } seq_flags_type;

   function automatic logic signed [POS_W-1:0] widen_coord(
      input logic signed [COORD_W-1:0] v
   );
      return {v[COORD_W-1], v};
   endfunction

endpackage

[hw/rtl/nearest_box_region_table.sv]
// ----------------------------------------------------------------------------
// nearest_box_region_table: ordered table of 3D boxes with nearest lookup
// Stream front end, output register and z margin register around the
// command sequencer.
// ----------------------------------------------------------------------------
// Usage:
// A command enters as one transfer on the req_ channel (tuser carries the
// command code, tdata the corners or query point and the delete index) and
// yields exactly one transfer on the rsp_ channel (tuser carries the status).
// Commands are handled one at a time; req_tready is high only while the
// sequencer is idle. Steps from input transfer to result valid:
//   add     three axis steps through the shared unit, then one write,
//   lookup  three axis steps and one compare per box scanned, one box at a
//           time through the single shared axis unit; the scan stops at the
//           first box that holds the point,
//   delete  one memory read and one write per entry moved down,
//           through the box storage,
//   clear and error results go straight to the result.
// The result sits in an output register, so the next command can be taken
// while the receiver stalls rsp_tready; a second result then waits inside
// the sequencer until the register frees up.
// Synchronous reset empties the table and sets z_margin to 512; the box
// storage itself is not cleared, since only entries below the count are used.
// csr_wr_en writes z_margin; it should only change while the block is idle.
// ----------------------------------------------------------------------------
module nearest_box_region_table import nbrt_pkg::*; #(
   parameter int MAX_BOXES = MAX_BOXES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Command channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata from bit 0: a_x, a_y, a_z, b_x, b_y, b_z, entry_index
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // tuser: cmd
   input  logic [CMD_W-1:0]       req_tuser,
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata from bit 0: inside_res, entry, excess, zero padding
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: status
   output logic [STATUS_W-1:0]    rsp_tuser,
   // z_margin register write.
   input  logic                   csr_wr_en,
   input  logic [MARGIN_W-1:0]    csr_wr_data
);

   logic [MARGIN_W-1:0]  margin_ff, margin_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_ff, rsp_in;

   req_item_type         req_item;
   seq_flags_type        flags;
   rsp_item_type         result;
   logic                 start;
   logic                 rsp_free;

   // Unpack the command transfer into its fields.
   always_comb begin
      req_item.cmd         = cmd_type'(req_tuser);
      req_item.a_x         = req_tdata[0*COORD_W +: COORD_W];
      req_item.a_y         = req_tdata[1*COORD_W +: COORD_W];
      req_item.a_z         = req_tdata[2*COORD_W +: COORD_W];
      req_item.b_x         = req_tdata[3*COORD_W +: COORD_W];
      req_item.b_y         = req_tdata[4*COORD_W +: COORD_W];
      req_item.b_z         = req_tdata[5*COORD_W +: COORD_W];
      req_item.entry_index = req_tdata[6*COORD_W +: ENTRY_W];
   end

   assign req_tready = flags.ready;
   assign start      = req_tvalid && flags.ready;

   // The output register is free when empty or being emptied this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   nbrt_seq #(
      .MAX_BOXES (MAX_BOXES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_item (req_item),
      .margin     (margin_ff),
      .rsp_free   (rsp_free),
      .flags      (flags),
      .result     (result)
   );

   always_comb begin
      margin_in    = csr_wr_en ? csr_wr_data : margin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (flags.done && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff    <= MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         margin_ff    <= margin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {{(RSP_DATA_W-1-ENTRY_W-SUM_W){1'b0}},
                        rsp_ff.excess, rsp_ff.entry, rsp_ff.inside_res};

endmodule

[hw/rtl/nbrt_box_mem.sv]
// ----------------------------------------------------------------------------
// nbrt_box_mem: box storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nbrt_box_mem import nbrt_pkg::*; #(
   parameter int DEPTH = MAX_BOXES_DEFAULT,
   parameter int AW    = 6
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  box_entry_type  wr_data,
   input  logic [AW-1:0]  rd_addr,
   output box_entry_type  rd_data
);

   box_entry_type mem [DEPTH];
   box_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/nbrt_axis_unit.sv]
// ----------------------------------------------------------------------------
// nbrt_axis_unit: shared per-axis arithmetic
// Sorts corners and accumulates the span, or accumulates the two corner
// distances to a query point, for one axis per cycle.
// ----------------------------------------------------------------------------
module nbrt_axis_unit import nbrt_pkg::*; (
   input  uop_type                  op,
   input  logic [SUM_W-1:0]         acc_in,
   input  logic signed [POS_W-1:0]  a_in,
   input  logic signed [POS_W-1:0]  b_in,
   input  logic signed [POS_W-1:0]  p_in,
   input  logic [MARGIN_W-1:0]      margin,
   input  logic                     widen,
   output logic signed [POS_W-1:0]  lo_out,
   output logic signed [POS_W-1:0]  hi_out,
   output logic [SUM_W-1:0]         acc_out
);

   logic signed [POS_W-1:0] mn;
   logic signed [POS_W-1:0] mx;
   logic signed [POS_W-1:0] ext;
   logic [POS_W:0]          span;
   logic [POS_W:0]          dl;
   logic [POS_W:0]          dh;
   logic [POS_W:0]          abs_l;
   logic [POS_W:0]          abs_h;
   logic [POS_W:0]          term;

   always_comb begin
      if (a_in < b_in) begin
         mn = a_in;
         mx = b_in;
      end else begin
         mn = b_in;
         mx = a_in;
      end
      ext    = widen ? $signed({{(POS_W-MARGIN_W){1'b0}}, margin}) : '0;
      lo_out = mn - ext;
      hi_out = mx + ext;
      span   = {hi_out[POS_W-1], hi_out} - {lo_out[POS_W-1], lo_out};

      // Distances of both stored corners from the query point.
      dl    = {a_in[POS_W-1], a_in} - {p_in[POS_W-1], p_in};
      dh    = {b_in[POS_W-1], b_in} - {p_in[POS_W-1], p_in};
      abs_l = dl[POS_W] ? (~dl + 1'b1) : dl;
      abs_h = dh[POS_W] ? (~dh + 1'b1) : dh;

      term    = (op == UOP_SORT) ? span : (abs_l + abs_h);
      acc_out = acc_in + SUM_W'(term);
   end

endmodule

[hw/rtl/nbrt_seq.sv]
// ----------------------------------------------------------------------------
// nbrt_seq: command sequencer
// Runs add, lookup, delete and clear over the box storage using the shared
// axis unit, and holds the result until the output register takes it.
// ----------------------------------------------------------------------------
module nbrt_seq import nbrt_pkg::*; #(
   parameter int MAX_BOXES = MAX_BOXES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_item_type         start_item,
   input  logic [MARGIN_W-1:0]  margin,
   input  logic                 rsp_free,
   output seq_flags_type        flags,
   output rsp_item_type         result
);

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam int IW = ((CW > ENTRY_W) ? CW : ENTRY_W) + 1;

   state_type                state_ff, state_in;
   logic [1:0]               axis_ff, axis_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            besti_ff, besti_in;
   logic [SUM_W-1:0]         acc_ff, acc_in;
   logic [BEST_W-1:0]        best_ff, best_in;
   req_item_type             item_ff, item_in;
   rsp_item_type             res_ff, res_in;
   logic signed [POS_W-1:0]  lo_ff [3];
   logic signed [POS_W-1:0]  lo_in [3];
   logic signed [POS_W-1:0]  hi_ff [3];
   logic signed [POS_W-1:0]  hi_in [3];

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   box_entry_type            wr_data;
   logic [AW-1:0]            rd_addr;
   box_entry_type            rd_data;

   uop_type                  u_op;
   logic signed [POS_W-1:0]  u_a;
   logic signed [POS_W-1:0]  u_b;
   logic signed [POS_W-1:0]  u_p;
   logic signed [POS_W-1:0]  u_lo;
   logic signed [POS_W-1:0]  u_hi;
   logic [SUM_W-1:0]         u_acc;

   logic [CW-1:0]            idx_next;
   logic                     is_full;
   logic                     del_ok;
   logic                     del_more_start;
   logic                     del_more;
   logic                     scan_last;
   logic [SUM_W:0]           diff;
   logic [SUM_W-1:0]         gap;
   logic                     dist_zero;
   logic                     better;
   logic [BEST_W-1:0]        new_best;
   logic [CW-1:0]            new_besti;

   nbrt_box_mem #(
      .DEPTH (MAX_BOXES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nbrt_axis_unit u_axis (
      .op      (u_op),
      .acc_in  (acc_ff),
      .a_in    (u_a),
      .b_in    (u_b),
      .p_in    (u_p),
      .margin  (margin),
      .widen   (axis_ff == AXIS_Z),
      .lo_out  (u_lo),
      .hi_out  (u_hi),
      .acc_out (u_acc)
   );

   // Status terms shared by both combinational blocks.
   always_comb begin
      idx_next       = idx_ff + 1'b1;
      is_full        = (count_ff == CW'(MAX_BOXES));
      del_ok         = IW'(start_item.entry_index) < IW'(count_ff);
      del_more_start = (IW'(start_item.entry_index) + IW'(1)) < IW'(count_ff);
      del_more       = (IW'(idx_ff) + IW'(2)) < IW'(count_ff);
      scan_last      = (idx_next == count_ff);
      diff           = {1'b0, acc_ff} - {1'b0, rd_data.ext};
      gap            = diff[SUM_W] ? '0 : diff[SUM_W-1:0];
      dist_zero      = (gap == '0);
      better         = BEST_W'(gap) < best_ff;
      new_best       = (dist_zero || better) ? BEST_W'(gap) : best_ff;
      new_besti      = (dist_zero || better) ? idx_ff : besti_ff;
   end

   // Operand selection for the shared axis unit.
   always_comb begin
      u_op = (state_ff == ST_ADD_AXIS) ? UOP_SORT : UOP_DIST;
      case (axis_ff)
         AXIS_X: begin
            u_p = widen_coord(item_ff.a_x);
            u_a = (u_op == UOP_SORT) ? widen_coord(item_ff.a_x) : rd_data.lo_x;
            u_b = (u_op == UOP_SORT) ? widen_coord(item_ff.b_x) : rd_data.hi_x;
         end
         AXIS_Y: begin
            u_p = widen_coord(item_ff.a_y);
            u_a = (u_op == UOP_SORT) ? widen_coord(item_ff.a_y) : rd_data.lo_y;
            u_b = (u_op == UOP_SORT) ? widen_coord(item_ff.b_y) : rd_data.hi_y;
         end
         default: begin
            u_p = widen_coord(item_ff.a_z);
            u_a = (u_op == UOP_SORT) ? widen_coord(item_ff.a_z) : rd_data.lo_z;
            u_b = (u_op == UOP_SORT) ? widen_coord(item_ff.b_z) : rd_data.hi_z;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (start_item.cmd)
                  CMD_ADD:    state_in = is_full ? ST_DONE : ST_ADD_AXIS;
                  CMD_LOOKUP: state_in = (count_ff == '0) ? ST_DONE : ST_LK_AXIS;
                  CMD_DELETE: state_in = (del_ok && del_more_start) ? ST_DEL_READ : ST_DONE;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD_AXIS:  state_in = (axis_ff == AXIS_Z) ? ST_ADD_WRITE : ST_ADD_AXIS;
         ST_ADD_WRITE: state_in = ST_DONE;
         ST_LK_AXIS:   state_in = (axis_ff == AXIS_Z) ? ST_LK_CMP : ST_LK_AXIS;
         ST_LK_CMP:    state_in = (dist_zero || scan_last) ? ST_DONE : ST_LK_AXIS;
         ST_DEL_READ:  state_in = ST_DEL_WRITE;
         ST_DEL_WRITE: state_in = del_more ? ST_DEL_READ : ST_DONE;
         ST_DONE:      state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      axis_in  = axis_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      besti_in = besti_ff;
      acc_in   = acc_ff;
      best_in  = best_ff;
      item_in  = item_ff;
      res_in   = res_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = rd_data;
      rd_addr  = idx_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            // Entry zero is read now so a lookup can start on the next cycle.
            rd_addr = '0;
            if (start) begin
               item_in  = start_item;
               axis_in  = AXIS_X;
               acc_in   = '0;
               idx_in   = '0;
               best_in  = EXCESS_INIT;
               besti_in = '0;
               res_in   = '{status: STATUS_OK, inside_res: 1'b0, entry: '0, excess: '0};
               case (start_item.cmd)
                  CMD_ADD: begin
                     if (is_full) begin
                        res_in.status = STATUS_FULL;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                     end
                  end
                  CMD_DELETE: begin
                     idx_in = CW'(start_item.entry_index);
                     if (!del_ok) begin
                        res_in.status = STATUS_RANGE;
                     end else begin
                        res_in.entry = start_item.entry_index;
                        if (!del_more_start) begin
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         ST_ADD_AXIS: begin
            lo_in[axis_ff] = u_lo;
            hi_in[axis_ff] = u_hi;
            acc_in         = u_acc;
            axis_in        = axis_ff + 1'b1;
         end
         ST_ADD_WRITE: begin
            wr_en        = 1'b1;
            wr_addr      = count_ff[AW-1:0];
            wr_data      = '{ext: acc_ff,
                             hi_z: hi_ff[2], hi_y: hi_ff[1], hi_x: hi_ff[0],
                             lo_z: lo_ff[2], lo_y: lo_ff[1], lo_x: lo_ff[0]};
            res_in.entry = ENTRY_W'(count_ff);
            count_in     = count_ff + 1'b1;
         end
         ST_LK_AXIS: begin
            acc_in  = u_acc;
            axis_in = axis_ff + 1'b1;
         end
         ST_LK_CMP: begin
            // Fetch the following box while this one is judged.
            rd_addr  = idx_next[AW-1:0];
            best_in  = new_best;
            besti_in = new_besti;
            idx_in   = idx_next;
            axis_in  = AXIS_X;
            acc_in   = '0;
            res_in   = '{status: STATUS_OK,
                         inside_res: (new_best == '0),
                         entry: ENTRY_W'(new_besti),
                         excess: new_best[SUM_W-1:0]};
         end
         ST_DEL_READ: begin
            rd_addr = idx_next[AW-1:0];
         end
         ST_DEL_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            idx_in  = idx_next;
            if (!del_more) begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff  <= axis_in;
      idx_ff   <= idx_in;
      besti_ff <= besti_in;
      acc_ff   <= acc_in;
      best_ff  <= best_in;
      item_ff  <= item_in;
      res_ff   <= res_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
   end

   assign flags.ready = (state_ff == ST_IDLE);
   assign flags.done  = (state_ff == ST_DONE);
   assign result      = res_ff;

endmodule
